### hw/rtl/lmlt_pkg.sv
// lmlt_pkg: shared types and constants for the lcd mode and line timing block
// mode codes, line and dot limits, and the word structs passed to the sequencer
// no dependencies
`timescale 1ns / 1ps

package lmlt_pkg;

	localparam logic [1:0] MODE_HBLANK   = 2'd0;
	localparam logic [1:0] MODE_VBLANK   = 2'd1;
	localparam logic [1:0] MODE_OAM      = 2'd2;
	localparam logic [1:0] MODE_TRANSFER = 2'd3;

	localparam logic [1:0] LOCK_VRAM = 2'b01;
	localparam logic [1:0] LOCK_OAM  = 2'b10;

	localparam logic [8:0] DOT_OAM_END   = 9'd80;
	localparam logic [8:0] DOT_LINE_END  = 9'd456;
	localparam logic [8:0] DOT_STARTUP   = 9'(456 - 64);
	localparam logic [7:0] LINE_VBLANK   = 8'd144;
	localparam logic [7:0] LINE_FRAME    = 8'd154;
	localparam logic [7:0] LINE_LAST     = 8'd153;

	typedef struct packed {
		logic       lcd_enable;
		logic [7:0] compare_line;
		logic       lyc_irq_enable;
		logic       vblank_stat_enable;
		logic       transfer_done;
	} dot_in_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] line;
		logic       coincidence;
		logic       vblank_irq;
		logic       stat_irq;
		logic       vram_locked;
		logic       oam_locked;
		logic       line_start;
		logic       frame_start;
	} dot_out_t;

endpackage

### hw/rtl/lmlt_seq.sv
// lmlt_seq: lcd mode sequencer state and next-state logic for one dot
// holds mode, dot and line counters, display and startup flags, locks
// depends on lmlt_pkg
`timescale 1ns / 1ps

module lmlt_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  lmlt_pkg::dot_in_t din,
	output lmlt_pkg::dot_out_t dout
);
	import lmlt_pkg::*;

	logic [1:0] mode_q;
	logic [8:0] dot_q;
	logic [7:0] line_q;
	logic       on_q;
	logic       startup_q;
	logic       coin_q;
	logic [1:0] locks_q;

	logic [1:0] mode_d;
	logic [8:0] dot_d;
	logic [7:0] line_d;
	logic       on_d;
	logic       startup_d;
	logic       coin_d;
	logic [1:0] locks_d;
	logic       p_vblank, p_stat, p_line, p_frame;
	logic [7:0] line_inc;
	logic [7:0] line_cmp;
	logic       match;

	always_comb begin
		mode_d    = mode_q;
		dot_d     = dot_q;
		line_d    = line_q;
		on_d      = on_q;
		startup_d = startup_q;
		coin_d    = coin_q;
		locks_d   = locks_q;
		p_vblank  = 1'b0;
		p_stat    = 1'b0;
		p_line    = 1'b0;
		p_frame   = 1'b0;
		line_inc  = '0;
		line_cmp  = '0;
		match     = 1'b0;

		if (!din.lcd_enable) begin
			if (on_q) begin
				locks_d = '0;
				mode_d  = MODE_VBLANK;
				dot_d   = '0;
				line_d  = '0;
				on_d    = 1'b0;
			end
		end else begin
			// display switched on: restart at line 0 in oam
			if (!on_q) begin
				line_d  = '0;
				p_line  = 1'b1;
				if (mode_d != MODE_HBLANK) begin
					p_frame = 1'b1;
				end
				mode_d  = MODE_OAM;
				locks_d = locks_d | LOCK_OAM;
				if (din.compare_line == 8'd0) begin
					coin_d = 1'b1;
					p_stat = p_stat | din.lyc_irq_enable;
				end
				on_d = 1'b1;
			end

			if (dot_d != '1) begin
				dot_d = dot_d + 9'd1;
			end

			line_inc = line_d + 8'd1;
			line_cmp = (line_inc <= LINE_LAST) ? line_inc : 8'd0;
			match    = (line_cmp == din.compare_line);

			unique case (mode_d)
				MODE_OAM: begin
					if (dot_d >= DOT_OAM_END) begin
						mode_d  = MODE_TRANSFER;
						locks_d = locks_d | LOCK_VRAM;
					end
				end
				MODE_TRANSFER: begin
					if (din.transfer_done) begin
						mode_d  = MODE_HBLANK;
						locks_d = '0;
					end
				end
				MODE_HBLANK: begin
					if (dot_d >= DOT_LINE_END) begin
						line_d = line_inc;
						coin_d = match;
						p_stat = p_stat | (match & din.lyc_irq_enable);
						if (line_inc >= LINE_VBLANK) begin
							mode_d   = MODE_VBLANK;
							locks_d  = '0;
							p_vblank = 1'b1;
							p_stat   = p_stat | din.vblank_stat_enable;
						end else begin
							mode_d  = MODE_OAM;
							locks_d = locks_d | LOCK_OAM;
							p_line  = 1'b1;
						end
						dot_d = '0;
					end
				end
				MODE_VBLANK: begin
					if (dot_d >= DOT_LINE_END) begin
						dot_d  = '0;
						line_d = line_inc;
						coin_d = match;
						p_stat = p_stat | (match & din.lyc_irq_enable);
						if (line_inc >= LINE_FRAME || startup_q) begin
							if (startup_q) begin
								startup_d = 1'b0;
								if (din.compare_line == 8'd0) begin
									coin_d = 1'b1;
									p_stat = p_stat | din.lyc_irq_enable;
								end
							end
							line_d  = '0;
							mode_d  = MODE_OAM;
							locks_d = locks_d | LOCK_OAM;
							p_line  = 1'b1;
							p_frame = 1'b1;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_VBLANK;
			dot_q     <= DOT_STARTUP;
			line_q    <= '0;
			on_q      <= 1'b1;
			startup_q <= 1'b1;
			coin_q    <= 1'b0;
			locks_q   <= '0;
		end else if (step) begin
			mode_q    <= mode_d;
			dot_q     <= dot_d;
			line_q    <= line_d;
			on_q      <= on_d;
			startup_q <= startup_d;
			coin_q    <= coin_d;
			locks_q   <= locks_d;
		end
	end

	always_comb begin
		dout.mode        = on_d ? mode_d : MODE_HBLANK;
		dout.line        = line_d;
		dout.coincidence = coin_d;
		dout.vblank_irq  = p_vblank;
		dout.stat_irq    = p_stat;
		dout.vram_locked = |(locks_d & LOCK_VRAM);
		dout.oam_locked  = |(locks_d & LOCK_OAM);
		dout.line_start  = p_line;
		dout.frame_start = p_frame;
	end

endmodule

### hw/rtl/lcd_mode_line_timing.sv
// lcd_mode_line_timing: top level of the lcd mode and line timing block
// input word register, sequencer, result word register
// depends on lmlt_pkg and lmlt_seq
`timescale 1ns / 1ps

// usage
// each input word is one dot tick carrying lcd enable, lyc, stat source enables
// and the pixel pipeline done flag. each accepted word yields exactly one
// result word: mode, ly, coincidence, interrupt pulses, memory locks and
// line/frame start pulses, all as they stand after that dot.
// a result word passes from the input register through the sequencer into the
// result register; one word per cycle is sustained while there is no stall.
// the rate is set by the sequencer update, which is combinational between the
// input register and the result register.
// reset marks both word registers empty and puts the sequencer in vblank at dot 392
// with the display on, so the first frame starts 64 dots in.
// when the receiver holds stall on a valid result word, the result register keeps
// its word, the sequencer does not advance, and in_stall rises once the input
// register is full; no word is lost or repeated.

module lcd_mode_line_timing (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       lcd_enable,
	input  logic [7:0] compare_line,
	input  logic       lyc_irq_enable,
	input  logic       vblank_stat_enable,
	input  logic       transfer_done,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] mode,
	output logic [7:0] line,
	output logic       coincidence,
	output logic       vblank_irq,
	output logic       stat_irq,
	output logic       vram_locked,
	output logic       oam_locked,
	output logic       line_start,
	output logic       frame_start
);
	import lmlt_pkg::*;

	logic     valid_s1;
	dot_in_t  din_s1;
	logic     out_valid_q;
	dot_out_t dout_q;
	dot_out_t dout_next;
	logic     advance;
	logic     accept;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			din_s1.lcd_enable         <= lcd_enable;
			din_s1.compare_line       <= compare_line;
			din_s1.lyc_irq_enable     <= lyc_irq_enable;
			din_s1.vblank_stat_enable <= vblank_stat_enable;
			din_s1.transfer_done      <= transfer_done;
		end
	end

	lmlt_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.din    (din_s1),
		.dout   (dout_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dout_q <= dout_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign mode        = dout_q.mode;
	assign line        = dout_q.line;
	assign coincidence = dout_q.coincidence;
	assign vblank_irq  = dout_q.vblank_irq;
	assign stat_irq    = dout_q.stat_irq;
	assign vram_locked = dout_q.vram_locked;
	assign oam_locked  = dout_q.oam_locked;
	assign line_start  = dout_q.line_start;
	assign frame_start = dout_q.frame_start;

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_start |-> line_start && line == 8'd0 && mode == MODE_OAM)
		else $error("frame start without line start at line 0 in oam");

	a_vblank_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && vblank_irq |-> mode == MODE_VBLANK && line == LINE_VBLANK)
		else $error("vblank interrupt outside vblank entry");

	a_hblank_unlocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (mode == MODE_HBLANK || mode == MODE_VBLANK)
			|-> !vram_locked && !oam_locked)
		else $error("memory locked during blanking");

	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line <= LINE_LAST)
		else $error("line count out of range");

	a_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with empty input register");

endmodule
